// ===== rtl/date_normalize_to_seconds_top_assert.svh =====
// Assertion macros for the date normalizer.
`ifndef DATE_NORMALIZE_TO_SECONDS_TOP_ASSERT_SVH
`define DATE_NORMALIZE_TO_SECONDS_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define DNS_ASSERT_SAME(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("dns assertion failed");
`define DNS_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("dns assertion failed");
`else
`define DNS_ASSERT_SAME(lbl, clk, rstn, ante, cons)
`define DNS_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

// ===== rtl/dns_pkg.sv =====
package dns_pkg;

    localparam logic [11:0] YEAR_LO   = 12'd1979;
    localparam logic [11:0] YEAR_HI   = 12'd2043;
    localparam logic [11:0] MONTH_LO  = 12'd1;
    localparam logic [11:0] MONTH_HI  = 12'd12;
    localparam logic [11:0] DAY_LO    = 12'd1;
    localparam logic [11:0] DAY_HI    = 12'd31;
    localparam logic [11:0] HOUR_LO   = 12'd0;
    localparam logic [11:0] HOUR_HI   = 12'd23;
    localparam logic [11:0] MINUTE_LO = 12'd0;
    localparam logic [11:0] MINUTE_HI = 12'd59;

    localparam logic [10:0] EPOCH_YEAR    = 11'd1978;
    localparam logic [14:0] DAYS_PER_YEAR = 15'd365;
    localparam logic [3:0]  MONTH_FEB     = 4'd2;
    localparam logic [3:0]  MONTH_MAR     = 4'd3;
    localparam logic [4:0]  FEB_LEAP_DAYS = 5'd29;
    localparam logic [16:0] SECS_PER_HOUR = 17'd3600;
    localparam logic [16:0] SECS_PER_MIN  = 17'd60;
    localparam logic [31:0] SECS_PER_DAY  = 32'd86400;

    typedef struct packed {
        logic [10:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [4:0]  hour;
        logic [5:0]  minute;
    } date_t;

    // wrap once by the range span, then clamp
    function automatic logic [11:0] fit_field(input logic [11:0] v, input logic [11:0] lo,
                                              input logic [11:0] hi, input logic wrap);
        logic [11:0] span;
        logic [11:0] w;
        span = hi - lo + 12'd1;
        w    = v;
        if (wrap) begin
            if (v < lo) begin
                w = v + span;
            end else if (v > hi) begin
                w = v - span;
            end
        end
        if (w < lo) begin
            w = lo;
        end
        if (w > hi) begin
            w = hi;
        end
        return w;
    endfunction

    function automatic logic [4:0] month_len(input logic [3:0] m);
        logic [4:0] n;
        case (m)
            4'd1:    n = 5'd31;
            4'd2:    n = 5'd28;
            4'd3:    n = 5'd31;
            4'd4:    n = 5'd30;
            4'd5:    n = 5'd31;
            4'd6:    n = 5'd30;
            4'd7:    n = 5'd31;
            4'd8:    n = 5'd31;
            4'd9:    n = 5'd30;
            4'd10:   n = 5'd31;
            4'd11:   n = 5'd30;
            4'd12:   n = 5'd31;
            default: n = 5'd0;
        endcase
        return n;
    endfunction

    // days before the first of month m, non-leap
    function automatic logic [8:0] cum_days(input logic [3:0] m);
        logic [8:0] n;
        case (m)
            4'd1:    n = 9'd0;
            4'd2:    n = 9'd31;
            4'd3:    n = 9'd59;
            4'd4:    n = 9'd90;
            4'd5:    n = 9'd120;
            4'd6:    n = 9'd151;
            4'd7:    n = 9'd181;
            4'd8:    n = 9'd212;
            4'd9:    n = 9'd243;
            4'd10:   n = 9'd273;
            4'd11:   n = 9'd304;
            4'd12:   n = 9'd334;
            default: n = 9'd0;
        endcase
        return n;
    endfunction

    // within 1979..2043 the only century year is 2000, a leap year
    function automatic logic is_leap(input logic [10:0] y);
        return (y[1:0] == 2'b00);
    endfunction

endpackage

// ===== rtl/date_normalize_to_seconds_top.sv =====
// Date normalizer: each request carries a date and time plus a mode bit; fields are wrapped
// once (wrap mode) and clamped to 1979-2043, 1-12, 1-31, 0-23, 0-59, the day is limited to
// the month length, and the result adds the seconds since 1 January 1978 00:00. Three
// register stages (field fit, day count, seconds multiply) take one request per clock while
// m_ready is high; a request passes d1_reg, d2_reg and d3_reg to m_valid. The output register
// holds a result while m_ready is low and the earlier stages fill until the pipeline is full.
`include "date_normalize_to_seconds_top_assert.svh"
module date_normalize_to_seconds_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_wrap_mode,
    input  logic [11:0] s_year,
    input  logic [3:0]  s_month,
    input  logic [4:0]  s_day,
    input  logic [4:0]  s_hour,
    input  logic [5:0]  s_minute,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [10:0] m_norm_year,
    output logic [3:0]  m_norm_month,
    output logic [4:0]  m_norm_day,
    output logic [4:0]  m_norm_hour,
    output logic [5:0]  m_norm_minute,
    output logic [31:0] m_raw_seconds
);
    import dns_pkg::*;

    logic        rdy1, rdy2, rdy3;
    logic        v1_reg, v2_reg, v3_reg;
    date_t       fit_next;
    date_t       d1_reg, d2_reg, d3_reg;
    date_t       d2_next;
    logic [14:0] days_next, days2_reg;
    logic [16:0] hms_next, hms2_reg;
    logic [31:0] secs_next, secs3_reg;
    logic [4:0]  lim;
    logic [4:0]  day_lim;
    logic [10:0] yr_full;
    logic [14:0] yr;
    logic        leap;
    logic        adj;

    assign rdy3    = !v3_reg || m_ready;
    assign rdy2    = !v2_reg || rdy3;
    assign rdy1    = !v1_reg || rdy2;
    assign s_ready = rdy1;

    dns_fit u_fit (
        .wrap_mode (s_wrap_mode),
        .year      (s_year),
        .month     (s_month),
        .day       (s_day),
        .hour      (s_hour),
        .minute    (s_minute),
        .fit       (fit_next)
    );

    // stage 2: day limit, day count, time of day
    always_comb begin
        leap    = is_leap(d1_reg.year);
        lim     = (d1_reg.month == MONTH_FEB && leap) ? FEB_LEAP_DAYS : month_len(d1_reg.month);
        day_lim = (d1_reg.day > lim) ? lim : d1_reg.day;
        adj     = leap && (d1_reg.month < MONTH_MAR);
        yr_full = d1_reg.year - EPOCH_YEAR;
        yr      = {8'd0, yr_full[6:0]};
        days_next = yr * DAYS_PER_YEAR + ((yr + 15'd2) >> 2) + {6'd0, cum_days(d1_reg.month)}
                  + {10'd0, day_lim} - 15'd1 - {14'd0, adj};
        hms_next  = {12'd0, d1_reg.hour} * SECS_PER_HOUR + {11'd0, d1_reg.minute} * SECS_PER_MIN;
        d2_next     = d1_reg;
        d2_next.day = day_lim;
    end

    // stage 3: seconds
    assign secs_next = {17'd0, days2_reg} * SECS_PER_DAY + {15'd0, hms2_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            if (rdy1) begin
                v1_reg <= s_valid;
            end
            if (rdy2) begin
                v2_reg <= v1_reg;
            end
            if (rdy3) begin
                v3_reg <= v2_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy1 && s_valid) begin
            d1_reg <= fit_next;
        end
        if (rdy2 && v1_reg) begin
            d2_reg    <= d2_next;
            days2_reg <= days_next;
            hms2_reg  <= hms_next;
        end
        if (rdy3 && v2_reg) begin
            d3_reg    <= d2_reg;
            secs3_reg <= secs_next;
        end
    end

    assign m_valid       = v3_reg;
    assign m_norm_year   = d3_reg.year;
    assign m_norm_month  = d3_reg.month;
    assign m_norm_day    = d3_reg.day;
    assign m_norm_hour   = d3_reg.hour;
    assign m_norm_minute = d3_reg.minute;
    assign m_raw_seconds = secs3_reg;

    `DNS_ASSERT_NEXT(a_accept_fills, aclk, aresetn, s_valid && s_ready, v1_reg)
    `DNS_ASSERT_NEXT(a_mid_holds, aclk, aresetn, v2_reg && !rdy2, v2_reg && $stable(days2_reg))
    `DNS_ASSERT_SAME(a_full_stalls, aclk, aresetn, v1_reg && v2_reg && v3_reg && !m_ready, !s_ready)
    `DNS_ASSERT_SAME(a_out_range, aclk, aresetn, m_valid,
        m_norm_month >= 4'd1 && m_norm_month <= 4'd12 && m_norm_day >= 5'd1 &&
        m_norm_hour <= 5'd23 && m_norm_minute <= 6'd59)
    `DNS_ASSERT_SAME(a_year_range, aclk, aresetn, m_valid,
        m_norm_year >= 11'd1979 && m_norm_year <= 11'd2043)

endmodule

// ===== rtl/dns_fit.sv =====
module dns_fit (
    input  logic          wrap_mode,
    input  logic [11:0]   year,
    input  logic [3:0]    month,
    input  logic [4:0]    day,
    input  logic [4:0]    hour,
    input  logic [5:0]    minute,
    output dns_pkg::date_t fit
);
    import dns_pkg::*;

    logic [11:0] year_w;
    logic [11:0] month_w;
    logic [11:0] day_w;
    logic [11:0] hour_w;
    logic [11:0] minute_w;

    always_comb begin
        year_w   = fit_field(year, YEAR_LO, YEAR_HI, wrap_mode);
        month_w  = fit_field({8'd0, month}, MONTH_LO, MONTH_HI, wrap_mode);
        day_w    = fit_field({7'd0, day}, DAY_LO, DAY_HI, wrap_mode);
        hour_w   = fit_field({7'd0, hour}, HOUR_LO, HOUR_HI, wrap_mode);
        minute_w = fit_field({6'd0, minute}, MINUTE_LO, MINUTE_HI, wrap_mode);
    end

    assign fit.year   = year_w[10:0];
    assign fit.month  = month_w[3:0];
    assign fit.day    = day_w[4:0];
    assign fit.hour   = hour_w[4:0];
    assign fit.minute = minute_w[5:0];

endmodule

// ===== test/tb.sv =====
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import dns_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 200;

    typedef struct packed {
        date_t       date;
        logic [31:0] secs;
    } date_result_t;

    class date_scoreboard;
        date_result_t expected_q[$];
        int           n_requests;
        int           n_wrap;
        int           n_out_of_range;
        int           n_checked;
        int           n_errors;

        function new();
            n_requests     = 0;
            n_wrap         = 0;
            n_out_of_range = 0;
            n_checked      = 0;
            n_errors       = 0;
        endfunction

        function int fit_range(int v, int lo, int hi, bit wrap);
            int w;
            w = v;
            if (wrap) begin
                if (w < lo) begin
                    w = w + (hi - lo + 1);
                end else if (w > hi) begin
                    w = w - (hi - lo + 1);
                end
            end
            if (w < lo) begin
                w = lo;
            end
            if (w > hi) begin
                w = hi;
            end
            return w;
        endfunction

        function bit leap(int y);
            return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
        endfunction

        function int month_days(int m, bit leap_yr);
            int n;
            case (m)
                4, 6, 9, 11: n = 30;
                2:           n = leap_yr ? 29 : 28;
                default:     n = 31;
            endcase
            return n;
        endfunction

        function date_result_t normalize(bit wrap, logic [11:0] yr, logic [3:0] mo,
                                         logic [4:0] dy, logic [4:0] hr, logic [5:0] mn);
            date_result_t r;
            int           y;
            int           m;
            int           d;
            int           h;
            int           mi;
            int           days;
            int           k;
            y  = fit_range(int'(yr), int'(YEAR_LO), int'(YEAR_HI), wrap);
            m  = fit_range(int'(mo), int'(MONTH_LO), int'(MONTH_HI), wrap);
            d  = fit_range(int'(dy), int'(DAY_LO), int'(DAY_HI), wrap);
            h  = fit_range(int'(hr), int'(HOUR_LO), int'(HOUR_HI), wrap);
            mi = fit_range(int'(mn), int'(MINUTE_LO), int'(MINUTE_HI), wrap);
            if (d > month_days(m, leap(y))) begin
                d = month_days(m, leap(y));
            end
            days = (y - int'(EPOCH_YEAR)) * 365 + (y - int'(EPOCH_YEAR) + 2) / 4;
            if (m < 3 && leap(y)) begin
                days = days - 1;
            end
            for (k = 1; k < m; k++) begin
                days = days + month_days(k, 1'b0);
            end
            days = days + d - 1;
            r.date.year   = 11'(y);
            r.date.month  = 4'(m);
            r.date.day    = 5'(d);
            r.date.hour   = 5'(h);
            r.date.minute = 6'(mi);
            r.secs        = 32'(days * 86400 + h * 3600 + mi * 60);
            return r;
        endfunction

        function void note_request(bit wrap, logic [11:0] yr, logic [3:0] mo,
                                   logic [4:0] dy, logic [4:0] hr, logic [5:0] mn);
            n_requests++;
            if (wrap) begin
                n_wrap++;
            end
            if (yr < YEAR_LO || yr > YEAR_HI || mo < MONTH_LO[3:0] || mo > MONTH_HI[3:0] ||
                dy == 5'd0 || hr > HOUR_HI[4:0] || mn > MINUTE_HI[5:0]) begin
                n_out_of_range++;
            end
            expected_q.push_back(normalize(wrap, yr, mo, dy, hr, mn));
        endfunction

        function void check_result(date_result_t got);
            date_result_t want;
            if (expected_q.size() == 0) begin
                n_errors++;
                if (n_errors <= 10) begin
                    $display("unexpected result %0d-%0d-%0d %0d:%0d secs %0d",
                             got.date.year, got.date.month, got.date.day,
                             got.date.hour, got.date.minute, got.secs);
                end
                return;
            end
            want = expected_q.pop_front();
            n_checked++;
            if (got.date.year !== want.date.year || got.date.month !== want.date.month ||
                got.date.day !== want.date.day || got.date.hour !== want.date.hour ||
                got.date.minute !== want.date.minute || got.secs !== want.secs) begin
                n_errors++;
                if (n_errors <= 10) begin
                    $display("mismatch: expected %0d-%0d-%0d %0d:%0d secs %0d",
                             want.date.year, want.date.month, want.date.day,
                             want.date.hour, want.date.minute, want.secs);
                    $display("          got      %0d-%0d-%0d %0d:%0d secs %0d",
                             got.date.year, got.date.month, got.date.day,
                             got.date.hour, got.date.minute, got.secs);
                end
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic        s_wrap_mode = 1'b0;
    logic [11:0] s_year = '0;
    logic [3:0]  s_month = '0;
    logic [4:0]  s_day = '0;
    logic [4:0]  s_hour = '0;
    logic [5:0]  s_minute = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [10:0] m_norm_year;
    logic [3:0]  m_norm_month;
    logic [4:0]  m_norm_day;
    logic [4:0]  m_norm_hour;
    logic [5:0]  m_norm_minute;
    logic [31:0] m_raw_seconds;

    date_scoreboard sb;
    bit             tx_idle_en = 1'b1;
    bit             rx_idle_en = 1'b1;
    int             hold_request = 0;
    int             cycle_count = 0;

    date_normalize_to_seconds_top u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_wrap_mode   (s_wrap_mode),
        .s_year        (s_year),
        .s_month       (s_month),
        .s_day         (s_day),
        .s_hour        (s_hour),
        .s_minute      (s_minute),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_norm_year   (m_norm_year),
        .m_norm_month  (m_norm_month),
        .m_norm_day    (m_norm_day),
        .m_norm_hour   (m_norm_hour),
        .m_norm_minute (m_norm_minute),
        .m_raw_seconds (m_raw_seconds)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready) begin
            sb.note_request(s_wrap_mode, s_year, s_month, s_day, s_hour, s_minute);
        end
    end

    always @(posedge aclk) begin
        date_result_t got;
        if (aresetn && m_valid && m_ready) begin
            got.date.year   = m_norm_year;
            got.date.month  = m_norm_month;
            got.date.day    = m_norm_day;
            got.date.hour   = m_norm_hour;
            got.date.minute = m_norm_minute;
            got.secs        = m_raw_seconds;
            sb.check_result(got);
        end
    end

    // result sink; a hold request is counted out here
    initial begin : result_sink
        int stall;
        while (!aresetn) @(posedge aclk);
        forever begin
            if (hold_request > 0) begin
                stall        = hold_request;
                hold_request = 0;
            end else if (rx_idle_en) begin
                stall = $urandom_range(0, 7);
            end else begin
                stall = 0;
            end
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
        end
    end

    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("timeout after %0d cycles, %0d results outstanding", cycle_count, sb.pending());
        $display("CHECK FAILED");
        $finish;
    end

    task automatic send_date(input bit wrap, input logic [11:0] yr, input logic [3:0] mo,
                             input logic [4:0] dy, input logic [4:0] hr, input logic [5:0] mn);
        int gap;
        gap = tx_idle_en ? $urandom_range(0, 7) : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_wrap_mode <= wrap;
        s_year      <= yr;
        s_month     <= mo;
        s_day       <= dy;
        s_hour      <= hr;
        s_minute    <= mn;
        do @(posedge aclk); while (!s_ready);
    endtask

    // mostly plausible dates, with edges and full-width noise mixed in
    task automatic send_random_dates(input int count);
        int          i;
        int          pick;
        logic [11:0] yr;
        logic [3:0]  mo;
        logic [4:0]  dy;
        logic [4:0]  hr;
        logic [5:0]  mn;
        for (i = 0; i < count; i++) begin
            pick = $urandom_range(0, 99);
            if (pick < 60) begin
                yr = 12'($urandom_range(1979, 2043));
            end else if (pick < 75) begin
                yr = 12'($urandom_range(1970, 2052));
            end else begin
                yr = 12'($urandom_range(0, 4095));
            end
            mo = ($urandom_range(0, 99) < 75) ? 4'($urandom_range(1, 12))
                                              : 4'($urandom_range(0, 15));
            pick = $urandom_range(0, 99);
            if (pick < 30) begin
                dy = 5'($urandom_range(28, 31));
            end else if (pick < 90) begin
                dy = 5'($urandom_range(1, 31));
            end else begin
                dy = 5'($urandom_range(0, 31));
            end
            hr = ($urandom_range(0, 99) < 80) ? 5'($urandom_range(0, 23))
                                              : 5'($urandom_range(0, 31));
            mn = ($urandom_range(0, 99) < 80) ? 6'($urandom_range(0, 59))
                                              : 6'($urandom_range(0, 63));
            send_date(1'($urandom_range(0, 1)), yr, mo, dy, hr, mn);
        end
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        do @(posedge aclk); while (sb.pending() != 0);
    endtask

    initial begin : main
        sb = new();
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        send_date(1'b0, 12'd1979, 4'd1,  5'd1,  5'd0,  6'd0);
        send_date(1'b0, 12'd2043, 4'd12, 5'd31, 5'd23, 6'd59);
        send_date(1'b0, 12'd0,    4'd0,  5'd0,  5'd0,  6'd0);
        send_date(1'b1, 12'd0,    4'd0,  5'd0,  5'd0,  6'd0);
        send_date(1'b0, 12'd4095, 4'd15, 5'd31, 5'd31, 6'd63);
        send_date(1'b1, 12'd4095, 4'd15, 5'd31, 5'd31, 6'd63);
        send_date(1'b1, 12'd1978, 4'd13, 5'd0,  5'd24, 6'd60);
        send_date(1'b1, 12'd2044, 4'd14, 5'd31, 5'd23, 6'd59);
        send_date(1'b0, 12'd1978, 4'd13, 5'd15, 5'd24, 6'd60);
        send_date(1'b0, 12'd2044, 4'd2,  5'd30, 5'd12, 6'd30);
        send_date(1'b0, 12'd2000, 4'd2,  5'd29, 5'd6,  6'd7);
        send_date(1'b0, 12'd2001, 4'd2,  5'd29, 5'd6,  6'd7);
        send_date(1'b1, 12'd2040, 4'd2,  5'd31, 5'd18, 6'd45);
        send_date(1'b0, 12'd1980, 4'd2,  5'd29, 5'd0,  6'd1);
        send_date(1'b0, 12'd1980, 4'd3,  5'd1,  5'd0,  6'd0);
        send_date(1'b0, 12'd1980, 4'd1,  5'd31, 5'd23, 6'd59);
        send_date(1'b0, 12'd2024, 4'd4,  5'd31, 5'd10, 6'd10);
        send_date(1'b0, 12'd2023, 4'd6,  5'd31, 5'd11, 6'd11);
        send_date(1'b0, 12'd2023, 4'd9,  5'd31, 5'd12, 6'd12);
        send_date(1'b0, 12'd2023, 4'd11, 5'd31, 5'd13, 6'd13);
        send_date(1'b1, 12'd2000, 4'd0,  5'd0,  5'd31, 6'd63);
        send_date(1'b1, 12'd1985, 4'd7,  5'd0,  5'd5,  6'd5);
        send_date(1'b1, 12'd1990, 4'd6,  5'd0,  5'd20, 6'd0);
        send_date(1'b0, 12'd1999, 4'd12, 5'd31, 5'd23, 6'd59);
        send_date(1'b1, 12'd2000, 4'd2,  5'd0,  5'd1,  6'd2);
        drain_results();

        send_random_dates(400);

        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        send_random_dates(200);

        // sink stalls long while requests keep coming
        hold_request = HOLD_CYCLES;
        send_random_dates(150);
        drain_results();

        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
        send_random_dates(350);

        drain_results();
        repeat (10) @(posedge aclk);

        if (sb.pending() != 0) begin
            $display("%0d expected results never arrived", sb.pending());
        end
        $display("requests: %0d, %0d in wrap mode, %0d with out-of-range fields",
                 sb.n_requests, sb.n_wrap, sb.n_out_of_range);
        $display("results checked: %0d, errors: %0d, cycles: %0d",
                 sb.n_checked, sb.n_errors, cycle_count);
        if (sb.n_errors == 0 && sb.pending() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule

// ===== files.f =====
+incdir+rtl
rtl/dns_pkg.sv
rtl/dns_fit.sv
rtl/date_normalize_to_seconds_top.sv
test/tb.sv
